>>> design/lsc_pkg.sv
// Package for the lat/lon to sphere cartesian block.
// Holds angle and fixed-point constants, the CORDIC arctangent table and shared types.
// No dependencies.
package lsc_pkg;

    localparam int CORDIC_STEPS = 24;
    localparam int BATCH_MAX    = 65536;

    // angles in 2^-16 degree units
    localparam logic signed [26:0] FULL_TURN    = 27'sd23592960;
    localparam logic signed [26:0] HALF_TURN    = 27'sd11796480;
    localparam logic signed [26:0] QUARTER_TURN = 27'sd5898240;
    localparam logic signed [26:0] MARKER       = -27'sd65470464;

    localparam logic signed [33:0] GAIN_INV = 34'sd652032874;
    localparam logic signed [33:0] ONE30    = 34'sd1073741824;

    localparam logic signed [47:0] Z_MARKER = -48'sd16760438784;
    localparam logic signed [70:0] OUT_MAX  = 71'sd140737488355327;
    localparam logic signed [70:0] OUT_MIN  = -71'sd140737488355328;

    typedef struct packed {
        logic signed [25:0] s;
        logic signed [25:0] c;
    } trig_t;

    // atan(2^-i) in degrees, 24 fraction bits
    function automatic logic signed [32:0] atan_deg(input logic [4:0] i);
        logic signed [32:0] v;
        unique case (i)
            5'd0:  v = 33'sd754974720;
            5'd1:  v = 33'sd445687602;
            5'd2:  v = 33'sd235489088;
            5'd3:  v = 33'sd119537938;
            5'd4:  v = 33'sd60000934;
            5'd5:  v = 33'sd30029717;
            5'd6:  v = 33'sd15018523;
            5'd7:  v = 33'sd7509720;
            5'd8:  v = 33'sd3754917;
            5'd9:  v = 33'sd1877466;
            5'd10: v = 33'sd938734;
            5'd11: v = 33'sd469367;
            5'd12: v = 33'sd234684;
            5'd13: v = 33'sd117342;
            5'd14: v = 33'sd58671;
            5'd15: v = 33'sd29335;
            5'd16: v = 33'sd14668;
            5'd17: v = 33'sd7334;
            5'd18: v = 33'sd3667;
            5'd19: v = 33'sd1833;
            5'd20: v = 33'sd917;
            5'd21: v = 33'sd458;
            5'd22: v = 33'sd229;
            5'd23: v = 33'sd115;
            default: v = 33'sd0;
        endcase
        return v;
    endfunction

    typedef enum logic [4:0] {
        C_IDLE = 5'b00001,
        C_RED  = 5'b00010,
        C_FOLD = 5'b00100,
        C_ROT  = 5'b01000,
        C_FIN  = 5'b10000
    } cordic_state_t;

    typedef enum logic [7:0] {
        S_IDLE = 8'b00000001,
        S_SLAT = 8'b00000010,
        S_WLAT = 8'b00000100,
        S_SLON = 8'b00001000,
        S_WLON = 8'b00010000,
        S_MULA = 8'b00100000,
        S_MULB = 8'b01000000,
        S_FIN  = 8'b10000000
    } seq_state_t;

endpackage

>>> design/lsc_cordic.sv
// Iterative sine/cosine unit: angle reduction, quadrant fold, 24-step circular CORDIC.
// Uses lsc_pkg for constants, the arctangent table and the trig_t result type.
module lsc_cordic
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic signed [26:0]  angle,
    output logic                done,
    output lsc_pkg::trig_t      trig
);

    lsc_pkg::cordic_state_t state_reg;
    logic signed [26:0] ang_reg;
    logic               flip_reg;
    logic signed [32:0] z_reg;
    logic signed [33:0] x_reg;
    logic signed [33:0] y_reg;
    logic [4:0]         i_reg;
    logic               done_reg;
    lsc_pkg::trig_t     trig_reg;

    logic signed [26:0] fold_r;
    logic               fold_flip;
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic signed [33:0] xf;
    logic signed [33:0] xc;
    logic signed [33:0] yc;
    logic signed [33:0] xr;
    logic signed [33:0] yr;

    always_comb
    begin
        if (ang_reg > lsc_pkg::QUARTER_TURN)
        begin
            fold_r    = lsc_pkg::HALF_TURN - ang_reg;
            fold_flip = 1'b1;
        end
        else if (ang_reg < -lsc_pkg::QUARTER_TURN)
        begin
            fold_r    = -lsc_pkg::HALF_TURN - ang_reg;
            fold_flip = 1'b1;
        end
        else
        begin
            fold_r    = ang_reg;
            fold_flip = 1'b0;
        end
    end

    assign dx = y_reg >>> i_reg;
    assign dy = x_reg >>> i_reg;

    // clamp to [-1,1] then round to 24 fraction bits
    assign xf = flip_reg ? -x_reg : x_reg;
    assign xc = (xf > lsc_pkg::ONE30) ? lsc_pkg::ONE30 :
                (xf < -lsc_pkg::ONE30) ? -lsc_pkg::ONE30 : xf;
    assign yc = (y_reg > lsc_pkg::ONE30) ? lsc_pkg::ONE30 :
                (y_reg < -lsc_pkg::ONE30) ? -lsc_pkg::ONE30 : y_reg;
    assign xr = xc + 34'sd32;
    assign yr = yc + 34'sd32;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lsc_pkg::C_IDLE;
            done_reg  <= 1'b0;
            i_reg     <= 5'd0;
        end
        else
        begin
            done_reg <= (state_reg == lsc_pkg::C_FIN);
            unique case (state_reg)
                lsc_pkg::C_IDLE:
                begin
                    if (start)
                    begin
                        ang_reg   <= angle;
                        state_reg <= lsc_pkg::C_RED;
                    end
                end
                lsc_pkg::C_RED:
                begin
                    if (ang_reg < -lsc_pkg::HALF_TURN)
                        ang_reg <= ang_reg + lsc_pkg::FULL_TURN;
                    else if (ang_reg >= lsc_pkg::HALF_TURN)
                        ang_reg <= ang_reg - lsc_pkg::FULL_TURN;
                    else
                        state_reg <= lsc_pkg::C_FOLD;
                end
                lsc_pkg::C_FOLD:
                begin
                    flip_reg  <= fold_flip;
                    z_reg     <= 33'(fold_r) <<< 8;
                    x_reg     <= lsc_pkg::GAIN_INV;
                    y_reg     <= 34'sd0;
                    i_reg     <= 5'd0;
                    state_reg <= lsc_pkg::C_ROT;
                end
                lsc_pkg::C_ROT:
                begin
                    if (z_reg >= 33'sd0)
                    begin
                        x_reg <= x_reg - dx;
                        y_reg <= y_reg + dy;
                        z_reg <= z_reg - lsc_pkg::atan_deg(i_reg);
                    end
                    else
                    begin
                        x_reg <= x_reg + dx;
                        y_reg <= y_reg - dy;
                        z_reg <= z_reg + lsc_pkg::atan_deg(i_reg);
                    end
                    i_reg <= i_reg + 5'd1;
                    if (i_reg == 5'(lsc_pkg::CORDIC_STEPS - 1))
                        state_reg <= lsc_pkg::C_FIN;
                end
                lsc_pkg::C_FIN:
                begin
                    trig_reg.s <= yr[31:6];
                    trig_reg.c <= xr[31:6];
                    state_reg  <= lsc_pkg::C_IDLE;
                end
                default:
                    state_reg <= lsc_pkg::C_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign trig = trig_reg;

endmodule

>>> design/latlon_to_sphere_cartesian_unit.sv
// Top level: lat/lon/elevation to scaled unit-sphere cartesian coordinates.
// Uses lsc_pkg and lsc_cordic (shared sine/cosine unit) plus one shared multiplier.
//
// Input stream (s_*): one point per item; tdata holds latitude, longitude and
// elevation, tlast marks the last point of a batch. Output stream (m_*): one
// result item per point; tdata holds x, y, z and the running valid count,
// tuser carries point_valid. cfg_* writes radial_scale and is always ready.
//
// Each point takes one pass of the sine/cosine unit for latitude and one for
// longitude (angle reduction of up to three steps, a fold, 24 CORDIC steps and
// a rounding step), then five multiplies through the single multiplier, each with
// a product step (S_MULA) and a result step (S_MULB), and a final step.
// A marker point skips the arithmetic: it goes from idle straight to the final
// step, which loads its result into the output register.
// s_tready is high only while the sequencer is idle.
// The result sits in an output register; the next item is taken while it
// waits, and a stalled receiver holds the sequencer only at its final step.
// Reset clears radial_scale, the batch count and all handshake state.
module latlon_to_sphere_cartesian_unit
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [71:0]  s_tdata,   // latitude[26:0], longitude[53:27], elevation[69:54]
    input  logic         s_tlast,   // batch_last
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [167:0] m_tdata,   // x_pos[47:0], y_pos[95:48], z_pos[143:96],
                                    // converted_count[160:144]
    output logic         m_tuser,   // point_valid
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [31:0]  cfg_data
);

    lsc_pkg::seq_state_t state_reg;
    logic [31:0]        rs_reg;
    logic [16:0]        cnt_reg;
    logic signed [26:0] lat_reg;
    logic signed [26:0] lon_reg;
    logic signed [15:0] elev_reg;
    logic               last_reg;
    logic               mark_reg;
    logic [2:0]         mstep_reg;
    lsc_pkg::trig_t     tlat_reg;
    lsc_pkg::trig_t     tlon_reg;
    logic signed [70:0] prod_reg;
    logic signed [37:0] r28_reg;
    logic signed [37:0] c28_reg;
    logic signed [47:0] x_reg;
    logic signed [47:0] y_reg;
    logic signed [47:0] z_reg;
    logic               out_valid_reg;
    logic [167:0]       out_data_reg;
    logic               out_user_reg;

    logic               c_start;
    logic signed [26:0] c_angle;
    logic               c_done;
    lsc_pkg::trig_t     c_trig;

    logic signed [37:0] a_op;
    logic signed [32:0] b_op;
    logic signed [70:0] prod_full;
    logic signed [70:0] r28_full;
    logic signed [70:0] c28_full;
    logic signed [70:0] q28_full;
    logic signed [47:0] q28_sat;
    logic               in_accept;
    logic               is_marker;
    logic [16:0]        cnt_inc;
    logic               out_load;

    lsc_cordic u_cordic
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (c_start),
        .angle (c_angle),
        .done  (c_done),
        .trig  (c_trig)
    );

    assign s_tready  = (state_reg == lsc_pkg::S_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign is_marker = ($signed(s_tdata[26:0]) == lsc_pkg::MARKER) ||
                       ($signed(s_tdata[53:27]) == lsc_pkg::MARKER);
    assign cfg_ready = 1'b1;

    assign c_start = (state_reg == lsc_pkg::S_SLAT) || (state_reg == lsc_pkg::S_SLON);
    assign c_angle = (state_reg == lsc_pkg::S_SLAT) ? lat_reg : lon_reg;

    // final step loads the output register once it is free or being drained
    assign out_load = (state_reg == lsc_pkg::S_FIN) && (!out_valid_reg || m_tready);

    always_comb
    begin
        case (mstep_reg)
            3'd0:
            begin
                a_op = 38'(elev_reg);
                b_op = $signed({1'b0, rs_reg});
            end
            3'd1:
            begin
                a_op = r28_reg;
                b_op = 33'(tlat_reg.c);
            end
            3'd2:
            begin
                a_op = r28_reg;
                b_op = 33'(tlat_reg.s);
            end
            3'd3:
            begin
                a_op = c28_reg;
                b_op = 33'(tlon_reg.s);
            end
            default:
            begin
                a_op = c28_reg;
                b_op = 33'(tlon_reg.c);
            end
        endcase
    end

    assign prod_full = a_op * b_op;

    // radial factor: 2^40 + elevation*scale, rounded to 28 fraction bits
    assign r28_full = (prod_reg + (71'sd1 <<< 40) + 71'sd2048) >>> 12;
    assign c28_full = (prod_reg + (71'sd1 <<< 23)) >>> 24;
    assign q28_full = (prod_reg + (71'sd1 <<< 27)) >>> 28;
    assign q28_sat  = (q28_full > lsc_pkg::OUT_MAX) ? lsc_pkg::OUT_MAX[47:0] :
                      (q28_full < lsc_pkg::OUT_MIN) ? lsc_pkg::OUT_MIN[47:0] :
                      q28_full[47:0];

    assign cnt_inc = (cnt_reg < 17'(lsc_pkg::BATCH_MAX)) ? cnt_reg + 17'd1 : cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lsc_pkg::S_IDLE;
            rs_reg        <= 32'd0;
            cnt_reg       <= 17'd0;
            mstep_reg     <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                rs_reg <= cfg_data;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                lsc_pkg::S_IDLE:
                begin
                    if (in_accept)
                    begin
                        lat_reg   <= $signed(s_tdata[26:0]);
                        lon_reg   <= $signed(s_tdata[53:27]);
                        elev_reg  <= $signed(s_tdata[69:54]);
                        last_reg  <= s_tlast;
                        mark_reg  <= is_marker;
                        mstep_reg <= 3'd0;
                        state_reg <= is_marker ? lsc_pkg::S_FIN : lsc_pkg::S_SLAT;
                    end
                end
                lsc_pkg::S_SLAT:
                    state_reg <= lsc_pkg::S_WLAT;
                lsc_pkg::S_WLAT:
                begin
                    if (c_done)
                    begin
                        tlat_reg  <= c_trig;
                        state_reg <= lsc_pkg::S_SLON;
                    end
                end
                lsc_pkg::S_SLON:
                    state_reg <= lsc_pkg::S_WLON;
                lsc_pkg::S_WLON:
                begin
                    if (c_done)
                    begin
                        tlon_reg  <= c_trig;
                        state_reg <= lsc_pkg::S_MULA;
                    end
                end
                lsc_pkg::S_MULA:
                begin
                    prod_reg  <= prod_full;
                    state_reg <= lsc_pkg::S_MULB;
                end
                lsc_pkg::S_MULB:
                begin
                    case (mstep_reg)
                        3'd0:    r28_reg <= r28_full[37:0];
                        3'd1:    c28_reg <= c28_full[37:0];
                        3'd2:    y_reg   <= q28_sat;
                        3'd3:    x_reg   <= q28_sat;
                        default: z_reg   <= q28_sat;
                    endcase
                    mstep_reg <= mstep_reg + 3'd1;
                    state_reg <= (mstep_reg == 3'd4) ? lsc_pkg::S_FIN : lsc_pkg::S_MULA;
                end
                lsc_pkg::S_FIN:
                begin
                    if (out_load)
                    begin
                        if (mark_reg)
                        begin
                            out_data_reg <= {7'd0, cnt_reg, lsc_pkg::Z_MARKER, 48'd0, 48'd0};
                            out_user_reg <= 1'b0;
                            cnt_reg      <= last_reg ? 17'd0 : cnt_reg;
                        end
                        else
                        begin
                            out_data_reg <= {7'd0, cnt_inc, z_reg, y_reg, x_reg};
                            out_user_reg <= 1'b1;
                            cnt_reg      <= last_reg ? 17'd0 : cnt_inc;
                        end
                        state_reg <= lsc_pkg::S_IDLE;
                    end
                end
                default:
                    state_reg <= lsc_pkg::S_IDLE;
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule
